// ----- sv/csvtok_pkg.sv -----
package csvtok_pkg;

    localparam int MAX_COLUMNS_DEF = 32;
    localparam int ROW_BITS_DEF    = 16;

    localparam int BYTE_W  = 8;
    localparam int COL_W   = 5;
    localparam int ROW_W   = 16;
    localparam int CCNT_W  = 6;
    localparam int CFG_A_W = 2;

    localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;

    localparam logic [BYTE_W-1:0] DELIM_RST   = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RST   = 8'd34;
    localparam logic [CCNT_W-1:0] COLCNT_RST  = 6'd1;

    localparam logic [CFG_A_W-1:0] REG_DELIMITER    = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_QUOTE_CHAR   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_COLUMN_COUNT = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_HAS_HEADER   = 2'd3;

    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_ABANDON = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        MODE_START      = 5'b00001,
        MODE_SKIP       = 5'b00010,
        MODE_PLAIN      = 5'b00100,
        MODE_QUOTED     = 5'b01000,
        MODE_QUOTE_SEEN = 5'b10000
    } mode_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] content_byte;
        logic [COL_W-1:0]  column_index;
        logic [ROW_W-1:0]  row_index;
        logic              is_header;
        logic              row_last;
    } result_t;

endpackage

// ----- sv/csv_field_tokenizer.sv -----
// Streaming CSV tokenizer. Each input beat carries one text byte (action 0) or a
// finish event (action 1) and yields at most one result beat: an unescaped content
// byte, a field-end mark with column, row, header flag and last-in-row flag, or an
// abandon mark when the stream finishes inside an open quoted field. One beat is
// taken every clock while s_ready is high; the tokenizer state is updated in the cycle of
// acceptance and the result lands in an output register backed by a one-entry skid
// register, so s_ready only drops while both are full. Write the configuration
// registers only while no beats are in flight.
module csv_field_tokenizer #(
    parameter int MAX_COLUMNS = csvtok_pkg::MAX_COLUMNS_DEF,
    parameter int ROW_BITS    = csvtok_pkg::ROW_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [csvtok_pkg::CFG_A_W-1:0]     cfg_index,
    input  logic [csvtok_pkg::BYTE_W-1:0]      cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [csvtok_pkg::BYTE_W-1:0]      s_text_byte,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_kind,
    output logic [csvtok_pkg::BYTE_W-1:0]      m_content_byte,
    output logic [csvtok_pkg::COL_W-1:0]       m_column_index,
    output logic [csvtok_pkg::ROW_W-1:0]       m_row_index,
    output logic                               m_is_header,
    output logic                               m_row_last
);
    import csvtok_pkg::*;

    localparam int CNT_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int MAXC_W = $clog2(MAX_COLUMNS + 1);
    localparam int EFF_W  = (MAXC_W > CCNT_W) ? MAXC_W : CCNT_W;
    localparam logic [EFF_W-1:0] MAXC = EFF_W'(MAX_COLUMNS);

    logic [BYTE_W-1:0] delim_reg;
    logic [BYTE_W-1:0] quote_reg;
    logic [CCNT_W-1:0] colcnt_reg;
    logic              has_header_reg;

    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic              hdr_done_reg, hdr_done_next;

    result_t           out_reg, skid_reg, res;
    logic              m_valid_reg, skid_valid_reg;
    logic              res_valid;

    logic              accept;
    logic              out_fire;
    logic              is_q, is_crlf, is_term;
    logic              at_start, fld_end, last;
    logic [EFF_W-1:0]  cc_ext, eff, col_p1;

    assign accept   = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign s_ready  = !skid_valid_reg;

    assign is_q    = (s_text_byte == quote_reg);
    assign is_crlf = (s_text_byte == BYTE_CR) || (s_text_byte == BYTE_LF);
    assign is_term = (s_text_byte == delim_reg) || is_crlf;

    assign cc_ext = EFF_W'(colcnt_reg);
    assign eff    = (cc_ext == '0) ? EFF_W'(1) : ((cc_ext > MAXC) ? MAXC : cc_ext);
    assign col_p1 = EFF_W'(col_reg) + EFF_W'(1);
    assign last   = (col_p1 >= eff);

    always_comb begin
        mode_next         = mode_reg;
        res_valid         = 1'b0;
        at_start          = 1'b0;
        fld_end           = 1'b0;
        res.kind          = KIND_BYTE;
        res.content_byte  = s_text_byte;
        res.column_index  = COL_W'(col_reg);
        res.row_index     = ROW_W'(row_reg);
        res.is_header     = !hdr_done_reg;
        res.row_last      = 1'b0;

        if (s_action == ACT_FINISH) begin
            mode_next = MODE_START;
            case (mode_reg)
                MODE_PLAIN, MODE_QUOTE_SEEN: begin
                    fld_end = 1'b1;
                end
                MODE_QUOTED: begin
                    res_valid = 1'b1;
                    res.kind  = KIND_ABANDON;
                end
                default: ;
            endcase
        end else begin
            case (mode_reg)
                MODE_PLAIN: begin
                    if (is_term) begin
                        fld_end   = 1'b1;
                        mode_next = MODE_SKIP;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (is_q) begin
                        mode_next = MODE_QUOTE_SEEN;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
                MODE_QUOTE_SEEN: begin
                    if (is_q) begin
                        mode_next = MODE_QUOTED;
                        res_valid = 1'b1;
                    end else begin
                        fld_end   = 1'b1;
                        mode_next = MODE_SKIP;
                    end
                end
                MODE_SKIP: begin
                    at_start = !is_crlf;
                end
                default: begin
                    at_start = 1'b1;
                end
            endcase

            if (at_start) begin
                if (is_q) begin
                    mode_next = MODE_QUOTED;
                end else if (is_term) begin
                    fld_end   = 1'b1;
                    mode_next = MODE_SKIP;
                end else begin
                    mode_next = MODE_PLAIN;
                    res_valid = 1'b1;
                end
            end
        end

        col_next      = col_reg;
        row_next      = row_reg;
        hdr_done_next = hdr_done_reg;
        if (fld_end) begin
            res_valid        = 1'b1;
            res.kind         = KIND_END;
            res.content_byte = '0;
            res.row_last     = last;
            if (last) begin
                col_next = '0;
                if (!hdr_done_reg) begin
                    hdr_done_next = 1'b1;
                end else if (row_reg != '1) begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end else if (res.kind != KIND_ABANDON) begin
            res.content_byte = res_valid ? s_text_byte : '0;
        end
        if (res.kind == KIND_ABANDON) begin
            res.content_byte = '0;
        end
    end

    // config and tokenizer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg      <= DELIM_RST;
            quote_reg      <= QUOTE_RST;
            colcnt_reg     <= COLCNT_RST;
            has_header_reg <= 1'b0;
            mode_reg       <= MODE_START;
            col_reg        <= '0;
            row_reg        <= '0;
            hdr_done_reg   <= 1'b1;
        end else begin
            if (accept) begin
                mode_reg     <= mode_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
            end
            if (cfg_wr_en && (cfg_index == REG_HAS_HEADER)) begin
                hdr_done_reg <= !cfg_wdata[0];
            end else if (accept) begin
                hdr_done_reg <= hdr_done_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DELIMITER:    delim_reg      <= cfg_wdata;
                    REG_QUOTE_CHAR:   quote_reg      <= cfg_wdata;
                    REG_COLUMN_COUNT: colcnt_reg     <= cfg_wdata[CCNT_W-1:0];
                    REG_HAS_HEADER:   has_header_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (m_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_reg <= skid_reg;
            end
        end else if (accept && res_valid) begin
            if (m_valid_reg && !m_ready) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = out_reg.kind;
    assign m_content_byte = out_reg.content_byte;
    assign m_column_index = out_reg.column_index;
    assign m_row_index    = out_reg.row_index;
    assign m_is_header    = out_reg.is_header;
    assign m_row_last     = out_reg.row_last;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without output entry");

    a_abandon_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_ABANDON)) |-> (!m_row_last && (m_content_byte == '0)))
        else $error("abandon beat carries row_last or data");

    a_wrap_clears_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && fld_end && last) |=> (col_reg == '0))
        else $error("column did not wrap on last field");

    a_header_needs_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        !has_header_reg |-> hdr_done_reg)
        else $error("header row open without header enabled");

    a_row_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (row_reg >= $past(row_reg)))
        else $error("row counter went backwards");

endmodule
